// ===== rtl/stip_pkg.sv =====
`timescale 1ns / 1ps
package stip_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [63:0] value;
    logic        overflow;
    logic        any_digits;
    logic [15:0] consumed;
  } result_t;

  typedef struct packed {
    logic       nul;
    logic       space;
    logic       plus;
    logic       minus;
    logic       apos;
    logic       zero;
    logic       x_mark;
    logic       b_mark;
    logic       dvalid;
    logic [5:0] dval;
    logic       first;
    logic       last;
  } cls_t;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] UPPER_OFS = 8'h37;
  localparam logic [7:0] LOWER_OFS = 8'h57;

  localparam logic REG_RADIX  = 1'b0;
  localparam logic REG_SIGNED = 1'b1;

  localparam logic [5:0] BASE_OCT = 6'd8;
  localparam logic [5:0] BASE_DEC = 6'd10;
  localparam logic [5:0] BASE_HEX = 6'd16;
  localparam logic [5:0] BASE_BIN = 6'd2;

endpackage

// ===== rtl/stip_fifo.sv =====
`timescale 1ns / 1ps
module stip_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

endmodule

// ===== rtl/stip_front.sv =====
`timescale 1ns / 1ps
module stip_front (
  input  stip_pkg::item_t item,
  output stip_pkg::cls_t  cls
);

  logic [7:0] c;
  logic [7:0] dig;
  logic [7:0] upr;
  logic [7:0] lwr;

  assign c   = item.ch;
  assign dig = c - stip_pkg::CH_ZERO;
  assign upr = c - stip_pkg::UPPER_OFS;
  assign lwr = c - stip_pkg::LOWER_OFS;

  always_comb begin
    cls        = '0;
    cls.first  = item.first;
    cls.last   = item.last;
    cls.nul    = (c == 8'h00);
    cls.space  = (c == stip_pkg::CH_SPACE) || (c inside {[8'd9:8'd13]});
    cls.plus   = (c == stip_pkg::CH_PLUS);
    cls.minus  = (c == stip_pkg::CH_MINUS);
    cls.apos   = (c == stip_pkg::CH_APOS);
    cls.zero   = (c == stip_pkg::CH_ZERO);
    cls.x_mark = (c == stip_pkg::CH_LX) || (c == stip_pkg::CH_UX);
    cls.b_mark = (c == stip_pkg::CH_LB) || (c == stip_pkg::CH_UB);
    if (c inside {[stip_pkg::CH_ZERO:stip_pkg::CH_NINE]}) begin
      cls.dvalid = 1'b1;
      cls.dval   = dig[5:0];
    end else if (c inside {[stip_pkg::CH_UA:stip_pkg::CH_UZ]}) begin
      cls.dvalid = 1'b1;
      cls.dval   = upr[5:0];
    end else if (c inside {[stip_pkg::CH_LA:stip_pkg::CH_LZ]}) begin
      cls.dvalid = 1'b1;
      cls.dval   = lwr[5:0];
    end
  end

endmodule

// ===== rtl/stip_back.sv =====
`timescale 1ns / 1ps
module stip_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [5:0]       radix,
  input  logic             signed_mode,
  input  stip_pkg::cls_t   cls,
  input  logic             cls_empty,
  output logic             cls_pop,
  output stip_pkg::result_t res,
  output logic             res_push,
  input  logic             res_full
);

  localparam logic [2:0] PH_SKIP   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  logic [2:0]            phase;
  logic                  negative;
  logic [63:0]           accum;
  logic [5:0]            active_base;
  logic                  seen_digit;
  logic                  range_error;
  logic [COUNT_BITS-1:0] char_count;

  logic [2:0]            phase_next;
  logic                  negative_next;
  logic [63:0]           accum_next;
  logic [5:0]            active_base_next;
  logic                  seen_digit_next;
  logic                  range_error_next;
  logic [COUNT_BITS-1:0] char_count_next;

  logic [2:0]            ph;
  logic                  neg;
  logic [63:0]           acc;
  logic [5:0]            base;
  logic                  seen;
  logic                  rerr;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] cnt_inc;

  logic                  radix_zero;
  logic                  hex_prefix;
  logic                  bin_prefix;
  logic                  lead_zero;
  logic                  do_digit;
  logic [5:0]            dig_base;
  logic [69:0]           sum;
  logic [63:0]           limit;
  logic                  go;
  logic [63:0]           sat;
  logic [COUNT_BITS+15:0] cnt_ext;

  assign go       = !cls_empty && !res_full;
  assign cls_pop  = go;
  assign res_push = go && cls.last;

  assign ph   = cls.first ? PH_SKIP : phase;
  assign neg  = cls.first ? 1'b0 : negative;
  assign acc  = cls.first ? 64'd0 : accum;
  assign base = cls.first ? 6'd0 : active_base;
  assign seen = cls.first ? 1'b0 : seen_digit;
  assign rerr = cls.first ? 1'b0 : range_error;
  assign cnt  = cls.first ? '0 : char_count;

  assign cnt_inc    = (cnt != '1) ? cnt + 1'b1 : cnt;
  assign radix_zero = (radix == 6'd0);
  assign hex_prefix = (radix_zero || radix == stip_pkg::BASE_HEX) && cls.x_mark;
  assign bin_prefix = (radix_zero || radix == stip_pkg::BASE_BIN) && cls.b_mark;
  assign lead_zero  = ((ph == PH_SKIP && !cls.space && !cls.plus && !cls.minus) ||
                       ph == PH_SIGN) && cls.zero;

  always_comb begin
    do_digit = 1'b0;
    dig_base = base;
    case (ph)
      PH_SKIP, PH_SIGN: begin
        do_digit = (ph == PH_SIGN || !(cls.space || cls.plus || cls.minus)) && !cls.zero;
        dig_base = radix_zero ? stip_pkg::BASE_DEC : radix;
      end
      PH_ZERO: begin
        do_digit = !hex_prefix && !bin_prefix;
        dig_base = radix_zero ? stip_pkg::BASE_OCT : radix;
      end
      PH_DIGITS: begin
        do_digit = 1'b1;
        dig_base = base;
      end
      default: begin
        do_digit = 1'b0;
        dig_base = base;
      end
    endcase
  end

  assign sum = {6'd0, acc} * {64'd0, dig_base} + {64'd0, cls.dval};

  always_comb begin
    if (signed_mode) limit = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    else limit = '1;
  end

  always_comb begin
    phase_next       = ph;
    negative_next    = neg;
    accum_next       = acc;
    active_base_next = base;
    seen_digit_next  = seen;
    range_error_next = rerr;
    char_count_next  = cnt;
    case (ph)
      PH_SKIP: begin
        if (cls.space) begin
          char_count_next = cnt_inc;
        end else if (cls.plus || cls.minus) begin
          negative_next   = cls.minus;
          char_count_next = cnt_inc;
          phase_next      = PH_SIGN;
        end
      end
      PH_ZERO: begin
        phase_next = PH_DIGITS;
        if (hex_prefix) begin
          active_base_next = stip_pkg::BASE_HEX;
          char_count_next  = cnt_inc;
        end else if (bin_prefix) begin
          active_base_next = stip_pkg::BASE_BIN;
          char_count_next  = cnt_inc;
        end
      end
      default: begin
      end
    endcase
    if (lead_zero) begin
      seen_digit_next = 1'b1;
      accum_next      = 64'd0;
      char_count_next = cnt_inc;
      phase_next      = PH_ZERO;
    end
    if (do_digit) begin
      active_base_next = dig_base;
      phase_next       = PH_DIGITS;
      if (cls.nul) begin
        phase_next = PH_DONE;
      end else if (cls.apos) begin
        char_count_next = cnt_inc;
      end else if (!cls.dvalid || cls.dval >= dig_base || dig_base == 6'd0) begin
        phase_next = PH_DONE;
      end else begin
        if (!rerr) begin
          if (sum > {6'd0, limit}) range_error_next = 1'b1;
          else accum_next = sum[63:0];
        end
        seen_digit_next = 1'b1;
        char_count_next = cnt_inc;
      end
    end
  end

  always_comb begin
    if (signed_mode) sat = negative_next ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    else sat = '1;
  end

  assign cnt_ext = {16'd0, (seen_digit_next ? char_count_next : {COUNT_BITS{1'b0}})};

  always_comb begin
    res.value      = range_error_next ? sat :
                     (negative_next ? 64'd0 - accum_next : accum_next);
    res.overflow   = range_error_next;
    res.any_digits = seen_digit_next;
    res.consumed   = (|cnt_ext[COUNT_BITS+15:16]) ? 16'hffff : cnt_ext[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SKIP;
      negative    <= 1'b0;
      accum       <= 64'd0;
      active_base <= 6'd0;
      seen_digit  <= 1'b0;
      range_error <= 1'b0;
      char_count  <= '0;
    end else if (go) begin
      if (cls.last) begin
        phase       <= PH_SKIP;
        negative    <= 1'b0;
        accum       <= 64'd0;
        active_base <= 6'd0;
        seen_digit  <= 1'b0;
        range_error <= 1'b0;
        char_count  <= '0;
      end else begin
        phase       <= phase_next;
        negative    <= negative_next;
        accum       <= accum_next;
        active_base <= active_base_next;
        seen_digit  <= seen_digit_next;
        range_error <= range_error_next;
        char_count  <= char_count_next;
      end
    end
  end

endmodule

// ===== rtl/string_to_integer_parser_top.sv =====
`timescale 1ns / 1ps
// string to integer parser, one character per transfer
// input side: push/full queue carrying item (ch, first, last); first starts
// a new string, last closes it and yields exactly one result
// result side: empty/pop queue carrying result (value, overflow, any_digits,
// consumed); characters without last yield nothing
// config: apb-style port, radix at address 0, signed_mode at address 4;
// write only while no string is in flight
// throughput: one character per cycle while the result queue has room; the
// parse state updates once per character through one 64x6 multiply-add and range check
// result path: a last character is stored in the character queue; the parse
// core then writes its result into the result queue, from which it is popped
// stall: when pop stays low the result queue fills, the parse core halts,
// the two-entry character queue fills and full rises; nothing is dropped
// reset: rst is synchronous; both queues empty, parse state cleared,
// radix returns to 0 and signed_mode to 1
module string_to_integer_parser_top #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  stip_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output stip_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [5:0]        radix;
  logic              signed_mode;
  logic              reg_sel;
  stip_pkg::cls_t    cls_in;
  stip_pkg::cls_t    cls_out;
  logic              cls_empty;
  logic              cls_pop;
  stip_pkg::result_t res;
  logic              res_push;
  logic              res_full;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= 6'd0;
      signed_mode <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        stip_pkg::REG_RADIX:  radix <= pwdata[5:0];
        stip_pkg::REG_SIGNED: signed_mode <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      stip_pkg::REG_RADIX:  prdata = {26'd0, radix};
      stip_pkg::REG_SIGNED: prdata = {31'd0, signed_mode};
      default:              prdata = 32'd0;
    endcase
  end

  stip_front u_front (
    .item (item),
    .cls  (cls_in)
  );

  stip_fifo #(
    .WIDTH ($bits(stip_pkg::cls_t))
  ) u_cls_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls_in),
    .full  (full),
    .pop   (cls_pop),
    .rdata (cls_out),
    .empty (cls_empty)
  );

  stip_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .radix       (radix),
    .signed_mode (signed_mode),
    .cls         (cls_out),
    .cls_empty   (cls_empty),
    .cls_pop     (cls_pop),
    .res         (res),
    .res_push    (res_push),
    .res_full    (res_full)
  );

  stip_fifo #(
    .WIDTH ($bits(stip_pkg::result_t))
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule
